// ===== rtl/lqi_pkg.sv =====
// Package for the LQI position controller: FSM and step types, engine command
// and response structs, fixed-point constants and register codes.
// No dependencies.
`default_nettype none

package lqi_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		SP_MUL, SP_DIV, SV_MUL, SV_DIV,
		SC_MUL, SC_DIV, SF_MUL, SI_MUL,
		SS_TAU, SS_POS, SS_VEL, SS_INT,
		SS_DIV, SG_MUL, SW_MUL, SW_DIV
	} step_t;

	typedef struct packed {
		logic               go;
		logic               is_div;
		logic signed [63:0] mcand;
		logic [23:0]        mplier;
		logic [63:0]        dvd;
		logic [19:0]        dsr;
		logic [6:0]         nbits;
	} eng_cmd_t;

	typedef struct packed {
		logic               done;
		logic signed [63:0] prod;
		logic [63:0]        quo;
		logic [19:0]        rem;
	} eng_rsp_t;

	localparam logic [2:0] CFG_REF    = 3'd0;
	localparam logic [2:0] CFG_GAIN   = 3'd1;
	localparam logic [2:0] CFG_FILTER = 3'd2;
	localparam logic [2:0] CFG_DT     = 3'd3;
	localparam logic [2:0] CFG_DBAND  = 3'd4;
	localparam logic [2:0] CFG_PERIOD = 3'd5;

	localparam logic [15:0] GAIN_RST   = 16'd2560;
	localparam logic [8:0]  FILTER_RST = 9'd179;
	localparam logic [15:0] DT_RST     = 16'd66;
	localparam logic [15:0] DBAND_RST  = 16'd655;
	localparam logic [15:0] PERIOD_RST = 16'd1999;

	localparam logic [63:0] POS_NUM = 64'd157696;
	localparam logic [19:0] POS_DEN = 20'd375;
	localparam logic [63:0] VEL_NUM = 64'd630784;
	localparam logic [19:0] VEL_DEN = 20'd15;
	localparam logic [63:0] CUR_NUM = 64'd51200000000;
	localparam logic [19:0] CUR_DEN = 20'd631449;

	localparam logic [23:0] W_TAU   = 24'd65;
	localparam logic [23:0] W_POS   = 24'd50000;
	localparam logic [23:0] W_VEL   = 24'd80000;
	localparam logic [23:0] W_INT   = 24'd5000000;
	localparam logic [19:0] W_SCALE = 20'd1000000;

	localparam logic signed [21:0] WRAP_JUMP_Q = 22'sd327680;
	localparam logic signed [21:0] TWO_PI_Q    = 22'sd411776;

	localparam logic [15:0] PWM_OFS  = 16'd360;
	localparam logic [15:0] PWM_STEP = 16'd4095;
	localparam logic [19:0] PWM_DEN  = 20'd49140;
	localparam logic [63:0] MAG_SAT  = 64'd12;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lqi_serial_unit.sv =====
// Shared serial arithmetic engine: shift-add multiply, one multiplier bit per
// cycle, and restoring divide, one quotient bit per cycle. Uses lqi_pkg.
`default_nettype none

module lqi_serial_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lqi_pkg::eng_cmd_t cmd,
	output lqi_pkg::eng_rsp_t      rsp
);
	import lqi_pkg::*;

	logic               busy_q;
	logic               div_q;
	logic [6:0]         cnt_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] mc_q;
	logic [23:0]        mp_q;
	logic [63:0]        dvd_q;
	logic [19:0]        rem_q;
	logic [19:0]        dsr_q;

	logic [20:0] trial;
	logic        fits;
	logic [20:0] rem_nx;
	logic        done;

	assign trial  = {rem_q, dvd_q[63]};
	assign fits   = trial >= {1'b0, dsr_q};
	assign rem_nx = fits ? trial - {1'b0, dsr_q} : trial;
	assign done   = busy_q && (div_q ? (cnt_q == 7'd0) : (mp_q == 24'd0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			div_q  <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (cmd.go) begin
			busy_q <= 1'b1;
			div_q  <= cmd.is_div;
			cnt_q  <= cmd.nbits;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && div_q) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			acc_q <= '0;
			mc_q  <= cmd.mcand;
			mp_q  <= cmd.mplier;
			dvd_q <= cmd.dvd;
			rem_q <= '0;
			dsr_q <= cmd.dsr;
		end else if (busy_q && !done) begin
			if (div_q) begin
				rem_q <= rem_nx[19:0];
				dvd_q <= {dvd_q[62:0], fits};
			end else begin
				if (mp_q[0])
					acc_q <= acc_q + mc_q;
				mc_q <= mc_q <<< 1;
				mp_q <= mp_q >> 1;
			end
		end
	end

	assign rsp.done = done;
	assign rsp.prod = acc_q;
	assign rsp.quo  = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/lqi_position_controller.sv =====
// LQI position controller top level: config registers, step sequencer, state
// and output register. Uses lqi_pkg and lqi_serial_unit.
//
//   channel | signals                                    | direction
//   in      | in_valid/in_ready, 4 sample fields         | into block
//   out     | out_valid/out_ready, 4 result fields       | out of block
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | into block
//
// After a sample's transfer, sixteen steps run one after another on the shared
// serial multiply/divide engine before out_valid; a multiply step runs until
// its multiplier has no bits left, so a sample's run depends on the bit
// lengths of the data-dependent multipliers. Reset clears the FSM, position,
// filter and integrator state, loads register defaults and empties the output.
// A result waiting on out_ready does not block the next sample from starting.
`default_nettype none

module lqi_position_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] encoder_count,
	input  wire logic [15:0] velocity_count,
	input  wire logic        turning_forward,
	input  wire logic [11:0] current_sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       drive_direction,
	output logic [15:0]      pwm_compare,
	output logic [31:0]      total_position_out,
	output logic [31:0]      filtered_current_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import lqi_pkg::*;

	state_t state_q, state_nx;
	step_t  step_q;

	logic signed [31:0] ref_q;
	logic [15:0]        gain_q;
	logic [8:0]         fw_q;
	logic [15:0]        dt_q;
	logic [15:0]        db_q;
	logic [15:0]        per_q;

	logic [20:0]        prev_q;
	logic signed [31:0] tot_q;
	logic signed [31:0] sm_q;
	logic signed [31:0] xi_q;

	logic [11:0]        cnt_q;
	logic [15:0]        vcnt_q;
	logic               fwd_q;
	logic [11:0]        adc_q;

	logic [30:0]        vel_q;
	logic [28:0]        cur_q;
	logic signed [55:0] sum_q;
	logic signed [36:0] s_q;
	logic [1:0]         dir_q;
	logic               msat_q;
	logic [3:0]         m_q;
	logic [15:0]        cmp_q;

	logic               out_valid_q;
	logic [1:0]         out_dir_q;
	logic [15:0]        out_cmp_q;
	logic [31:0]        out_tot_q;
	logic [31:0]        out_cur_q;

	eng_cmd_t cmd;
	eng_rsp_t rsp;

	lqi_serial_unit u_eng (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	logic [8:0]         w_eff;
	logic signed [32:0] err;
	logic signed [33:0] err_x;
	logic signed [33:0] db_x;
	logic               outside;
	logic [55:0]        sum_abs;
	logic [15:0]        pwm_x;
	logic [20:0]        pos_nx;
	logic signed [21:0] delta;
	logic signed [33:0] tot_nx;
	logic signed [63:0] f_sum;
	logic signed [63:0] i_add;
	logic [35:0]        s_mag;
	logic signed [63:0] g_shr;
	logic [63:0]        g_abs;
	logic [63:0]        mag;
	logic               load_out;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign w_eff     = (fw_q > 9'd256) ? 9'd256 : fw_q;
	assign err       = 33'(tot_q) - 33'(ref_q);
	assign err_x     = 34'(err);
	assign db_x      = $signed({18'd0, db_q});
	assign outside   = (err_x > db_x) || (err_x < -db_x);
	assign sum_abs   = sum_q[55] ? 56'(-sum_q) : 56'(sum_q);
	assign pwm_x     = msat_q ? 16'd0 : 16'(PWM_OFS + PWM_STEP * {12'd0, m_q});

	assign pos_nx = rsp.quo[20:0];
	assign delta  = $signed({1'b0, pos_nx}) - $signed({1'b0, prev_q});
	always_comb begin
		tot_nx = 34'(tot_q) + 34'(delta);
		if (fwd_q && (delta < -WRAP_JUMP_Q))
			tot_nx = 34'(tot_q) + 34'($signed({1'b0, pos_nx}));
		else if (!fwd_q && (delta > WRAP_JUMP_Q))
			tot_nx = 34'(tot_q) - 34'(TWO_PI_Q - $signed({1'b0, pos_nx}));
	end

	assign f_sum = rsp.prod + $signed({27'd0, cur_q, 8'd0});
	assign i_add = rsp.prod >>> 16;
	assign s_mag = rsp.quo[35:0] + {35'd0, (rsp.rem != 20'd0)};
	assign g_shr = rsp.prod >>> 8;
	assign g_abs = g_shr[63] ? 64'(-g_shr) : 64'(g_shr);
	assign mag   = g_abs >> 16;

	always_comb begin
		cmd        = '0;
		cmd.go     = (state_q == ST_ISSUE);
		case (step_q)
			SP_MUL: begin
				cmd.mcand  = $signed(POS_NUM);
				cmd.mplier = 24'(cnt_q);
			end
			SP_DIV: begin
				cmd.is_div = 1'b1;
				cmd.dvd    = {rsp.prod[29:0], 34'd0};
				cmd.dsr    = POS_DEN;
				cmd.nbits  = 7'd30;
			end
			SV_MUL: begin
				cmd.mcand  = $signed(VEL_NUM);
				cmd.mplier = 24'(vcnt_q);
			end
			SV_DIV: begin
				cmd.is_div = 1'b1;
				cmd.dvd    = {rsp.prod[35:0], 28'd0};
				cmd.dsr    = VEL_DEN;
				cmd.nbits  = 7'd36;
			end
			SC_MUL: begin
				cmd.mcand  = $signed(CUR_NUM);
				cmd.mplier = 24'(adc_q);
			end
			SC_DIV: begin
				cmd.is_div = 1'b1;
				cmd.dvd    = {rsp.prod[47:0], 16'd0};
				cmd.dsr    = CUR_DEN;
				cmd.nbits  = 7'd48;
			end
			SF_MUL: begin
				cmd.mcand  = 64'(sm_q) - $signed({35'd0, cur_q});
				cmd.mplier = 24'(w_eff);
			end
			SI_MUL: begin
				cmd.mcand  = 64'(err);
				cmd.mplier = 24'(dt_q);
			end
			SS_TAU: begin
				cmd.mcand  = 64'(sm_q);
				cmd.mplier = W_TAU;
			end
			SS_POS: begin
				cmd.mcand  = 64'(tot_q);
				cmd.mplier = W_POS;
			end
			SS_VEL: begin
				cmd.mcand  = $signed({33'd0, vel_q});
				cmd.mplier = W_VEL;
			end
			SS_INT: begin
				cmd.mcand  = 64'(xi_q);
				cmd.mplier = W_INT;
			end
			SS_DIV: begin
				cmd.is_div = 1'b1;
				cmd.dvd    = {sum_abs, 8'd0};
				cmd.dsr    = W_SCALE;
				cmd.nbits  = 7'd56;
			end
			SG_MUL: begin
				cmd.mcand  = 64'(s_q);
				cmd.mplier = 24'(gain_q);
			end
			SW_MUL: begin
				cmd.mcand  = $signed({48'd0, per_q});
				cmd.mplier = 24'(pwm_x);
			end
			SW_DIV: begin
				cmd.is_div = 1'b1;
				cmd.dvd    = {rsp.prod[31:0], 32'd0};
				cmd.dsr    = PWM_DEN;
				cmd.nbits  = 7'd32;
			end
			default: begin
				cmd.go = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nx = ST_ISSUE;
			end
			ST_ISSUE: begin
				state_nx = ST_WAIT;
			end
			ST_WAIT: begin
				if (rsp.done)
					state_nx = (step_q == SW_DIV) ? ST_DONE : ST_ISSUE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= SP_MUL;
		end else begin
			state_q <= state_nx;
			if (in_valid && in_ready)
				step_q <= SP_MUL;
			else if (state_q == ST_WAIT && rsp.done && step_q != SW_DIV)
				step_q <= step_t'(4'(step_q) + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= '0;
			gain_q <= GAIN_RST;
			fw_q   <= FILTER_RST;
			dt_q   <= DT_RST;
			db_q   <= DBAND_RST;
			per_q  <= PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REF:    ref_q  <= cfg_data;
				CFG_GAIN:   gain_q <= cfg_data[15:0];
				CFG_FILTER: fw_q   <= cfg_data[8:0];
				CFG_DT:     dt_q   <= cfg_data[15:0];
				CFG_DBAND:  db_q   <= cfg_data[15:0];
				CFG_PERIOD: per_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			tot_q  <= '0;
			sm_q   <= '0;
			xi_q   <= '0;
		end else if (state_q == ST_WAIT && rsp.done) begin
			case (step_q)
				SP_DIV: begin
					prev_q <= pos_nx;
					tot_q  <= sat32(64'(tot_nx));
				end
				SF_MUL: sm_q <= sat32(f_sum >>> 8);
				SI_MUL: begin
					if (outside)
						xi_q <= sat32(64'(xi_q) + i_add);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cnt_q  <= encoder_count;
			vcnt_q <= velocity_count;
			fwd_q  <= turning_forward;
			adc_q  <= current_sample;
		end
		if (state_q == ST_WAIT && rsp.done) begin
			case (step_q)
				SV_DIV: vel_q <= (rsp.quo > 64'h7FFFFFFF) ? 31'h7FFFFFFF : rsp.quo[30:0];
				SC_DIV: cur_q <= rsp.quo[28:0];
				SS_TAU: sum_q <= rsp.prod[55:0];
				SS_POS: sum_q <= sum_q + rsp.prod[55:0];
				SS_VEL: sum_q <= sum_q - rsp.prod[55:0];
				SS_INT: sum_q <= sum_q + rsp.prod[55:0];
				SS_DIV: s_q <= sum_q[55] ? -$signed({1'b0, s_mag}) : $signed({1'b0, rsp.quo[35:0]});
				SG_MUL: begin
					dir_q  <= (g_shr < 0) ? 2'd1 : ((g_shr > 0) ? 2'd2 : 2'd0);
					msat_q <= mag >= MAG_SAT;
					m_q    <= mag[3:0];
				end
				SW_DIV: cmp_q <= msat_q ? per_q : rsp.quo[15:0];
				default: ;
			endcase
		end
		if (load_out) begin
			out_dir_q <= dir_q;
			out_cmp_q <= cmp_q;
			out_tot_q <= tot_q;
			out_cur_q <= sm_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid            = out_valid_q;
	assign drive_direction      = out_dir_q;
	assign pwm_compare          = out_cmp_q;
	assign total_position_out   = out_tot_q;
	assign filtered_current_out = out_cur_q;

`ifndef SYNTHESIS
	a_start_issue: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_ISSUE)
		else $error("sample transfer did not start the sequencer");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == ST_WAIT)
		else $error("engine finished outside a wait step");

	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive_direction != 2'd3)
		else $error("illegal drive direction code");

	a_pwm_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pwm_compare <= per_q)
		else $error("pwm compare above period");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for lqi_position_controller: a clocked driver feeds
// samples from a queue, a monitor predicts each result and checks it per field.
// Depends on lqi_pkg and the controller RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import lqi_pkg::*;

	typedef struct {
		logic [11:0] enc;
		logic [15:0] vel;
		logic        fwd;
		logic [11:0] cur;
	} sample_t;

	typedef struct {
		logic [1:0]  dir;
		logic [15:0] pwm;
		logic [31:0] total;
		logic [31:0] filt;
	} drive_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [11:0] encoder_count = '0;
	logic [15:0] velocity_count = '0;
	logic        turning_forward = 1'b0;
	logic [11:0] current_sample = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  drive_direction;
	logic [15:0] pwm_compare;
	logic [31:0] total_position_out;
	logic [31:0] filtered_current_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_REF;
	logic [31:0] cfg_data = '0;

	lqi_position_controller i_dut (.*);

	always #2 clk = ~clk;

	sample_t sample_q[$];
	drive_t  pending_results[$];

	longint ref_pos = 0, gain = 2560, lambda = 179, dt = 66, dband = 655, period = 1999;
	longint prev_angle = 0, total_angle = 0, smooth_cur = 0, err_integral = 0;

	logic in_took = 1'b0, cfg_took = 1'b0;
	logic burst_mode = 1'b0, long_hold_req = 1'b0, long_hold_done = 1'b0;
	int   in_gap = 0, out_gap = 0, hold_left = 0, idle_cycles = 0;
	int   mismatches = 0, fails = 0, n_in = 0, n_out = 0, n_cfg = 0;
	int   n_zero = 0, n_fwd = 0, n_rev = 0;

	function automatic longint clamp_s32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_div(input longint a, input longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic drive_t control_step(input sample_t s);
		longint pos, vel, cur, w, delta, tot, err, acc, u, mag;
		longint unsigned cmp;
		drive_t r;
		pos = (longint'(s.enc) * 77 * 65536) / 12000;
		vel = clamp_s32((longint'(s.vel) * 77 * 65536) / 120);
		cur = clamp_s32((longint'(s.cur) * 781250 * 4095 * 65536) / (631449 * 4095));
		w = (lambda > 256) ? 256 : lambda;
		smooth_cur = clamp_s32(floor_div(w * smooth_cur + (256 - w) * cur, 256));
		delta = pos - prev_angle;
		prev_angle = pos;
		tot = total_angle;
		if (s.fwd)
			tot += (delta < -327680) ? pos : delta;
		else if (delta > 327680)
			tot -= (411776 - pos);
		else
			tot += delta;
		total_angle = clamp_s32(tot);
		err = total_angle - ref_pos;
		if (err > dband || err < -dband)
			err_integral = clamp_s32(err_integral + floor_div(err * dt, 65536));
		acc = smooth_cur * 65 + total_angle * 50000 - vel * 80000 + err_integral * 5000000;
		u = -floor_div(gain * floor_div(acc, 1000000), 256);
		r.dir = (u > 0) ? 2'd1 : (u < 0) ? 2'd2 : 2'd0;
		mag = ((u < 0) ? -u : u) >>> 16;
		cmp = (longint'(period) * (360 + 4095 * mag)) / 49140;
		if (cmp > period) cmp = period;
		r.pwm = cmp[15:0];
		r.total = total_angle[31:0];
		r.filt = smooth_cur[31:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_mode) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// sender: hold payload until transfer, then advance
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (sample_q.size() > 0 && arst_n) begin
				sample_t s;
				s = sample_q.pop_front();
				encoder_count <= s.enc;
				velocity_count <= s.vel;
				turning_forward <= s.fwd;
				current_sample <= s.cur;
				in_valid <= 1'b1;
				in_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (long_hold_req && !long_hold_done && hold_left == 0) hold_left = 3000;
		if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) long_hold_done = 1'b1;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			out_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		drive_t e;
		in_took <= in_valid && in_ready;
		cfg_took <= cfg_valid && cfg_ready;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles > 30000) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("tb_top failed");
			$finish;
		end
		if (cfg_valid && cfg_ready) begin
			n_cfg++;
			case (cfg_index)
				CFG_REF:    ref_pos = longint'($signed(cfg_data));
				CFG_GAIN:   gain = cfg_data[15:0];
				CFG_FILTER: lambda = cfg_data[8:0];
				CFG_DT:     dt = cfg_data[15:0];
				CFG_DBAND:  dband = cfg_data[15:0];
				CFG_PERIOD: period = cfg_data[15:0];
				default: ;
			endcase
		end
		if (in_valid && in_ready) begin
			n_in++;
			pending_results.push_back(control_step('{encoder_count, velocity_count,
				turning_forward, current_sample}));
		end
		if (out_valid && out_ready) begin
			n_out++;
			if (pending_results.size() == 0) begin
				fails++;
				if (mismatches++ < 10) $display("unexpected result at %0t", $time);
			end else begin
				e = pending_results.pop_front();
				case (drive_direction)
					2'd0: n_zero++;
					2'd1: n_fwd++;
					default: n_rev++;
				endcase
				if (e.dir !== drive_direction || e.pwm !== pwm_compare ||
						e.total !== total_position_out || e.filt !== filtered_current_out) begin
					fails++;
					if (mismatches++ < 10)
						$display("result %0d: exp dir %0d pwm %0d pos %h cur %h, got %0d %0d %h %h",
							n_out, e.dir, e.pwm, e.total, e.filt, drive_direction,
							pwm_compare, total_position_out, filtered_current_out);
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_sample(input int e, input int v, input bit f, input int c);
		sample_q.push_back('{e[11:0], v[15:0], f, c[11:0]});
	endtask

	task automatic drain();
		while (sample_q.size() > 0 || in_valid || pending_results.size() > 0)
			@(negedge clk);
		repeat (500) @(negedge clk);
	endtask

	initial begin
		int track, step, r;
		bit dir_f;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, unwrap in both directions
		add_sample(0, 0, 1, 0);
		add_sample(4095, 65535, 1, 4095);
		add_sample(10, 1, 1, 1);
		add_sample(4095, 65535, 0, 4095);
		add_sample(10, 300, 0, 2048);
		add_sample(4000, 0, 0, 0);
		add_sample(4095, 0, 1, 4095);
		add_sample(0, 65535, 0, 0);
		add_sample(2048, 32768, 1, 2048);
		add_sample(2047, 32767, 0, 2047);
		add_sample(0, 0, 1, 4095);
		add_sample(4095, 12, 0, 100);
		add_sample(1, 1, 0, 1);
		add_sample(0, 0, 0, 0);
		add_sample(0, 0, 0, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			burst_mode = (p == 3 || p == 6);
			case (p)
				0: begin
					write_reg(CFG_REF, 32'h8000_0000); write_reg(CFG_GAIN, 16'd0);
					write_reg(CFG_FILTER, 9'd0); write_reg(CFG_DT, 16'd0);
					write_reg(CFG_DBAND, 16'd0); write_reg(CFG_PERIOD, 16'd1);
				end
				1: begin
					write_reg(CFG_REF, 32'h7FFF_FFFF); write_reg(CFG_GAIN, 16'hFFFF);
					write_reg(CFG_FILTER, 9'd256); write_reg(CFG_DT, 16'hFFFF);
					write_reg(CFG_DBAND, 16'hFFFF); write_reg(CFG_PERIOD, 16'hFFFF);
				end
				2: begin
					write_reg(CFG_FILTER, 9'd511); write_reg(CFG_PERIOD, 16'd0);
					write_reg(CFG_REF, 32'd0); write_reg(CFG_DBAND, 16'd655);
				end
				default: begin
					write_reg(CFG_REF, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000));
					write_reg(CFG_GAIN, $urandom_range(0, 5000));
					write_reg(CFG_FILTER, $urandom_range(0, 300));
					write_reg(CFG_DT, $urandom_range(0, 1000));
					write_reg(CFG_DBAND, $urandom);
					write_reg(CFG_PERIOD, $urandom_range(1, 65535));
				end
			endcase
			if (p == 4) long_hold_req = 1'b1;
			track = $urandom_range(0, 4095);
			for (int i = 0; i < 200; i++) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					// smooth trajectory, wraps through zero
					step = $urandom_range(0, 300);
					dir_f = $urandom_range(0, 5) != 0 ? (p % 2 == 0) : (p % 2 != 0);
					track = dir_f ? (track + step) % 4096 : (track - step + 4096) % 4096;
					add_sample(track, step * $urandom_range(0, 200), dir_f,
						$urandom_range(1500, 2600));
				end else begin
					add_sample($urandom_range(0, 4095), $urandom_range(0, 65535),
						$urandom_range(0, 1), $urandom_range(0, 4095));
				end
			end
			drain();
		end

		$display("%0d samples, %0d results, %0d register writes; drive off/fwd/rev %0d/%0d/%0d",
			n_in, n_out, n_cfg, n_zero, n_fwd, n_rev);
		$display("%0d mismatches", mismatches);
		if (fails == 0 && pending_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire
